### hdl/assert_macros.svh
// assertion macros used by the wav header parser top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked once reset is released
`define WPH_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("wph: same-cycle check failed");

// next-cycle implication, checked once reset is released
`define WPH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("wph: next-cycle check failed");

`endif

### hdl/wph_pkg.sv
// types, codes and constants of the wav header parser
package wph_pkg;

	localparam int POSITION_BITS_DEF = 31;

	localparam logic [31:0] TagRiff = 32'h5249_4646;
	localparam logic [31:0] TagWave = 32'h5741_5645;
	localparam logic [31:0] TagFmt  = 32'h666D_7420;
	localparam logic [31:0] TagData = 32'h6461_7461;

	localparam int MinFileLen   = 44;
	localparam int FirstChunk   = 12;
	localparam int FmtMinLen    = 16;
	localparam int BitsFieldAt  = 14;
	localparam int WaveTagAt    = 8;
	localparam int TagLen       = 4;
	localparam logic [7:0] FmtPcm     = 8'd1;
	localparam logic [7:0] Bits16     = 8'd16;

	typedef enum logic [3:0] {
		PH_RIFF = 4'b0001,
		PH_HDR  = 4'b0010,
		PH_BODY = 4'b0100,
		PH_PAD  = 4'b1000
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NOT_WAV   = 3'd1,
		ST_FMT_SMALL = 3'd2,
		ST_MISSING   = 3'd3,
		ST_UNSUPP    = 3'd4,
		ST_EMPTY     = 3'd5
	} status_t;

	typedef struct packed {
		logic        fmt_ok;
		logic        bits_ok;
		logic [15:0] chans;
		logic [31:0] rate;
	} fmt_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] rate;
		logic [15:0] chans;
		logic [30:0] offset;
		logic [30:0] size;
	} report_t;

	// byte i of a four character tag, first character first
	function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] i);
		logic [7:0] b;
		case (i)
			2'd0:    b = tag[31:24];
			2'd1:    b = tag[23:16];
			2'd2:    b = tag[15:8];
			default: b = tag[7:0];
		endcase
		return b;
	endfunction

endpackage

### hdl/wph_if.sv
// handshake channels of the wav header parser: byte stream in, report out
interface wph_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] wav_byte;
	logic       last_byte;

	modport source(output valid, output wav_byte, output last_byte, input ready);
	modport sink(input valid, input wav_byte, input last_byte, output ready);
endinterface

interface wph_report_if;
	logic        valid;
	logic        ready;
	logic [2:0]  parse_status;
	logic [31:0] sample_rate;
	logic [15:0] channel_count;
	logic [30:0] data_offset;
	logic [30:0] data_size;

	modport source(output valid, output parse_status, output sample_rate,
		output channel_count, output data_offset, output data_size, input ready);
	modport sink(input valid, input parse_status, input sample_rate,
		input channel_count, input data_offset, input data_size, output ready);
endinterface

### hdl/wph_step.sv
// chunk walker: parser state and the per-word update, plus the report it would give
module wph_step #(
	parameter int POSITION_BITS = wph_pkg::POSITION_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [7:0]        wav_byte,
	input  logic              last_byte,
	output wph_pkg::report_t  report
);

	localparam logic [POSITION_BITS-1:0] PosMax     = '1;
	localparam logic [POSITION_BITS-1:0] PosWaveAt  = POSITION_BITS'(wph_pkg::WaveTagAt);
	localparam logic [POSITION_BITS-1:0] PosTagLen  = POSITION_BITS'(wph_pkg::TagLen);
	localparam logic [POSITION_BITS-1:0] PosHdrEnd  = POSITION_BITS'(wph_pkg::FirstChunk - 1);
	localparam logic [POSITION_BITS-1:0] PosMinLast = POSITION_BITS'(wph_pkg::MinFileLen - 1);
	localparam logic [4:0] BodyIdxSat = 5'(wph_pkg::FmtMinLen);
	localparam logic [4:0] BitsIdx    = 5'(wph_pkg::BitsFieldAt);

	wph_pkg::phase_t          phase_q, phase_n;
	logic [POSITION_BITS-1:0] pos_q;
	logic                     hdr_ok_q, hdr_ok_n;
	logic [31:0]              tag_q, tag_n;
	logic [31:0]              len_q, len_n;
	logic [31:0]              left_q, left_n;
	logic [2:0]               hdr_idx_q, hdr_idx_n;
	logic [4:0]               body_idx_q, body_idx_n;
	wph_pkg::fmt_t            pend_q, pend_n;
	wph_pkg::fmt_t            fmt_q, fmt_n;
	logic                     fmt_found_q, fmt_found_n;
	logic                     data_found_q, data_found_n;
	logic                     fmt_err_q, fmt_err_n;
	logic [30:0]              data_off_q, data_off_n;
	logic [30:0]              data_size_q, data_size_n;

	logic [31:0] len_shift;
	logic [31:0] fin_len;
	logic [31:0] data_start;
	logic        fin;
	wph_pkg::status_t status;

	assign len_shift  = {wav_byte, len_q[31:8]};
	assign fin_len    = (phase_q == wph_pkg::PH_HDR) ? len_shift : len_q;
	// payload start: the chunk's final byte sits at the current position
	assign data_start = 32'(pos_q) + 32'd1 - fin_len;

	always_comb begin
		phase_n      = phase_q;
		hdr_ok_n     = hdr_ok_q;
		tag_n        = tag_q;
		len_n        = len_q;
		left_n       = left_q;
		hdr_idx_n    = hdr_idx_q;
		body_idx_n   = body_idx_q;
		pend_n       = pend_q;
		fmt_n        = fmt_q;
		fmt_found_n  = fmt_found_q;
		data_found_n = data_found_q;
		fmt_err_n    = fmt_err_q;
		data_off_n   = data_off_q;
		data_size_n  = data_size_q;
		fin          = 1'b0;

		case (phase_q)
			wph_pkg::PH_RIFF: begin
				if (pos_q < PosTagLen &&
					wav_byte != wph_pkg::tag_byte(wph_pkg::TagRiff, pos_q[1:0])) begin
					hdr_ok_n = 1'b0;
				end
				if (pos_q >= PosWaveAt &&
					wav_byte != wph_pkg::tag_byte(wph_pkg::TagWave, pos_q[1:0])) begin
					hdr_ok_n = 1'b0;
				end
				if (pos_q >= PosHdrEnd) begin
					phase_n   = wph_pkg::PH_HDR;
					hdr_idx_n = 3'd0;
				end
			end
			wph_pkg::PH_HDR: begin
				if (!hdr_idx_q[2]) begin
					tag_n = {tag_q[23:0], wav_byte};
				end else begin
					len_n = len_shift;
				end
				hdr_idx_n = hdr_idx_q + 3'd1;
				if (hdr_idx_q == 3'd7) begin
					pend_n = '0;
					if (len_shift == 32'd0) begin
						fin = 1'b1;
					end else begin
						phase_n    = wph_pkg::PH_BODY;
						left_n     = len_shift;
						body_idx_n = 5'd0;
					end
				end
			end
			wph_pkg::PH_BODY: begin
				if (tag_q == wph_pkg::TagFmt) begin
					case (body_idx_q)
						5'd0: pend_n.fmt_ok = (wav_byte == wph_pkg::FmtPcm);
						5'd1: if (wav_byte != 8'd0) pend_n.fmt_ok = 1'b0;
						5'd2: pend_n.chans[7:0]   = pend_q.chans[7:0] | wav_byte;
						5'd3: pend_n.chans[15:8]  = pend_q.chans[15:8] | wav_byte;
						5'd4: pend_n.rate[7:0]    = pend_q.rate[7:0] | wav_byte;
						5'd5: pend_n.rate[15:8]   = pend_q.rate[15:8] | wav_byte;
						5'd6: pend_n.rate[23:16]  = pend_q.rate[23:16] | wav_byte;
						5'd7: pend_n.rate[31:24]  = pend_q.rate[31:24] | wav_byte;
						BitsIdx: pend_n.bits_ok = (wav_byte == wph_pkg::Bits16);
						BitsIdx + 5'd1: if (wav_byte != 8'd0) pend_n.bits_ok = 1'b0;
						default: pend_n = pend_q;
					endcase
				end
				// only the first sixteen payload positions matter
				if (body_idx_q != BodyIdxSat) begin
					body_idx_n = body_idx_q + 5'd1;
				end
				left_n = left_q - 32'd1;
				if (left_q == 32'd1) begin
					fin = 1'b1;
				end
			end
			wph_pkg::PH_PAD: begin
				phase_n   = wph_pkg::PH_HDR;
				hdr_idx_n = 3'd0;
			end
			default: begin
				phase_n = wph_pkg::PH_RIFF;
			end
		endcase

		if (fin) begin
			if (tag_q == wph_pkg::TagFmt) begin
				if (fin_len < 32'(wph_pkg::FmtMinLen)) begin
					fmt_err_n = 1'b1;
				end else begin
					fmt_n       = pend_n;
					fmt_found_n = 1'b1;
				end
			end else if (tag_q == wph_pkg::TagData) begin
				data_off_n   = data_start[30:0];
				data_size_n  = fin_len[30:0];
				data_found_n = 1'b1;
			end
			phase_n   = fin_len[0] ? wph_pkg::PH_PAD : wph_pkg::PH_HDR;
			hdr_idx_n = 3'd0;
			left_n    = 32'd0;
		end
	end

	always_comb begin
		if (!hdr_ok_n || pos_q < PosMinLast) begin
			status = wph_pkg::ST_NOT_WAV;
		end else if (fmt_err_n) begin
			status = wph_pkg::ST_FMT_SMALL;
		end else if (!fmt_found_n || !data_found_n) begin
			status = wph_pkg::ST_MISSING;
		end else if (!fmt_n.fmt_ok || !fmt_n.bits_ok ||
			fmt_n.chans == 16'd0 || fmt_n.rate == 32'd0) begin
			status = wph_pkg::ST_UNSUPP;
		end else if (data_size_n == 31'd0) begin
			status = wph_pkg::ST_EMPTY;
		end else begin
			status = wph_pkg::ST_OK;
		end

		report.status = status;
		if (status == wph_pkg::ST_OK || status == wph_pkg::ST_EMPTY) begin
			report.rate   = fmt_n.rate;
			report.chans  = fmt_n.chans;
			report.offset = data_off_n;
			report.size   = data_size_n;
		end else begin
			report.rate   = 32'd0;
			report.chans  = 16'd0;
			report.offset = 31'd0;
			report.size   = 31'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= wph_pkg::PH_RIFF;
			pos_q        <= '0;
			hdr_ok_q     <= 1'b1;
			tag_q        <= '0;
			len_q        <= '0;
			left_q       <= '0;
			hdr_idx_q    <= '0;
			body_idx_q   <= '0;
			pend_q       <= '0;
			fmt_q        <= '0;
			fmt_found_q  <= 1'b0;
			data_found_q <= 1'b0;
			fmt_err_q    <= 1'b0;
			data_off_q   <= '0;
			data_size_q  <= '0;
		end else if (take) begin
			if (last_byte) begin
				// file done: start over for the next one
				phase_q      <= wph_pkg::PH_RIFF;
				pos_q        <= '0;
				hdr_ok_q     <= 1'b1;
				tag_q        <= '0;
				len_q        <= '0;
				left_q       <= '0;
				hdr_idx_q    <= '0;
				body_idx_q   <= '0;
				pend_q       <= '0;
				fmt_q        <= '0;
				fmt_found_q  <= 1'b0;
				data_found_q <= 1'b0;
				fmt_err_q    <= 1'b0;
				data_off_q   <= '0;
				data_size_q  <= '0;
			end else begin
				phase_q      <= phase_n;
				if (pos_q != PosMax) begin
					pos_q <= pos_q + POSITION_BITS'(1);
				end
				hdr_ok_q     <= hdr_ok_n;
				tag_q        <= tag_n;
				len_q        <= len_n;
				left_q       <= left_n;
				hdr_idx_q    <= hdr_idx_n;
				body_idx_q   <= body_idx_n;
				pend_q       <= pend_n;
				fmt_q        <= fmt_n;
				fmt_found_q  <= fmt_found_n;
				data_found_q <= data_found_n;
				fmt_err_q    <= fmt_err_n;
				data_off_q   <= data_off_n;
				data_size_q  <= data_size_n;
			end
		end
	end

endmodule

### hdl/wav_pcm16_header_parser.sv
// Top level of the WAV (PCM16) header parser. Takes one file byte per clock on
// the bytes channel, last_byte marking the end of the file, and walks the RIFF
// chunks as they stream past. One report word leaves on the report channel for
// each file in the cycle after its last byte is taken, and waits in an output
// register until it is taken; bytes keep flowing while the report sink keeps up,
// and ready drops only while a report is held and the sink is not ready, so a
// stalled sink stops the byte stream until the held report is taken. Sustained
// rate is one byte per cycle while the report sink keeps up, one walker update per byte.
// The byte position counter is POSITION_BITS wide and saturates on very long files.
`include "assert_macros.svh"

module wav_pcm16_header_parser #(
	parameter int POSITION_BITS = wph_pkg::POSITION_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	wph_byte_if.sink           bytes,
	wph_report_if.source       report
);

	logic             take;
	logic             load;
	logic             rep_valid_q;
	wph_pkg::report_t rep_next;
	wph_pkg::report_t rep_q;

	// a waiting report only blocks the input when it is not leaving this cycle
	assign bytes.ready = !rep_valid_q || report.ready;
	assign take        = bytes.valid && bytes.ready;
	assign load        = take && bytes.last_byte;

	wph_step #(
		.POSITION_BITS(POSITION_BITS)
	) u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.wav_byte  (bytes.wav_byte),
		.last_byte (bytes.last_byte),
		.report    (rep_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rep_valid_q <= 1'b0;
		end else if (load) begin
			rep_valid_q <= 1'b1;
		end else if (report.ready) begin
			rep_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rep_q <= '0;
		end else if (load) begin
			rep_q <= rep_next;
		end
	end

	assign report.valid         = rep_valid_q;
	assign report.parse_status  = rep_q.status;
	assign report.sample_rate   = rep_q.rate;
	assign report.channel_count = rep_q.chans;
	assign report.data_offset   = rep_q.offset;
	assign report.data_size     = rep_q.size;

	`WPH_ASSERT_NEXT(a_last_gives_report, clk, arst_n, load, rep_valid_q)
	`WPH_ASSERT_NOW(a_stall_only_on_report, clk, arst_n, !bytes.ready, rep_valid_q)
	`WPH_ASSERT_NOW(a_status_in_range, clk, arst_n, rep_valid_q,
		rep_q.status == wph_pkg::ST_OK || rep_q.status == wph_pkg::ST_NOT_WAV ||
		rep_q.status == wph_pkg::ST_FMT_SMALL || rep_q.status == wph_pkg::ST_MISSING ||
		rep_q.status == wph_pkg::ST_UNSUPP || rep_q.status == wph_pkg::ST_EMPTY)
	`WPH_ASSERT_NOW(a_fail_fields_zero, clk, arst_n,
		rep_valid_q && rep_q.status != wph_pkg::ST_OK && rep_q.status != wph_pkg::ST_EMPTY,
		rep_q.rate == 32'd0 && rep_q.chans == 16'd0 &&
		rep_q.offset == 31'd0 && rep_q.size == 31'd0)

endmodule
